### rtl/hcbd_pkg.sv
// hcbd_pkg: shared types and codes of the chunked body decoder
// used by hcbd_size_line and http_chunked_body_decoder; no dependencies
package hcbd_pkg;

    // default width of the chunk length
    localparam int LEN_BITS_DEF = 32;

    // decoder phase codes
    localparam logic [1:0] PH_SIZE  = 2'd0;
    localparam logic [1:0] PH_DATA  = 2'd1;
    localparam logic [1:0] PH_TRAIL = 2'd2;

    // number parser stage codes
    localparam logic [2:0] ST_BLANK  = 3'd0;
    localparam logic [2:0] ST_SIGN   = 3'd1;
    localparam logic [2:0] ST_ZERO   = 3'd2;
    localparam logic [2:0] ST_PREFIX = 3'd3;
    localparam logic [2:0] ST_DIGITS = 3'd4;
    localparam logic [2:0] ST_REST   = 3'd5;
    localparam logic [2:0] ST_OVER   = 3'd6;

    // result kinds
    localparam logic [1:0] KIND_DATA  = 2'd0;
    localparam logic [1:0] KIND_DONE  = 2'd1;
    localparam logic [1:0] KIND_ERROR = 2'd2;

    // characters
    localparam logic [7:0] CH_LF = 8'h0A;
    localparam logic [7:0] CH_CR = 8'h0D;

    // per-line parser flags
    typedef struct packed {
        logic [2:0] stage;
        logic       nonempty;
        logic       negative;
        logic       seen_digit;
    } t_line_flags;

endpackage

### rtl/hcbd_size_line.sv
// hcbd_size_line: next state of the chunk-size parser for one character
// that is neither CR nor LF; depends on hcbd_pkg
module hcbd_size_line import hcbd_pkg::*; #(
    parameter int LEN_BITS = LEN_BITS_DEF
) (
    input  logic [7:0]          i_char,
    input  t_line_flags         i_flags,
    input  logic [LEN_BITS-1:0] i_acc,
    output t_line_flags         o_flags,
    output logic [LEN_BITS-1:0] o_acc
);

    logic       is_hex;
    logic [3:0] hex_val;
    logic       is_blank;
    logic       do_first;
    logic       do_add;

    // hex digit decode
    always_comb begin
        is_hex  = 1'b1;
        hex_val = 4'd0;
        if (i_char >= 8'h30 && i_char <= 8'h39) begin
            hex_val = 4'(i_char - 8'h30);
        end else if (i_char >= 8'h61 && i_char <= 8'h66) begin
            hex_val = 4'(i_char - 8'h57);
        end else if (i_char >= 8'h41 && i_char <= 8'h46) begin
            hex_val = 4'(i_char - 8'h37);
        end else begin
            is_hex = 1'b0;
        end
    end

    // space, tab, vertical tab, form feed
    assign is_blank = (i_char == 8'h20) || (i_char == 8'h09) ||
                      (i_char == 8'h0B) || (i_char == 8'h0C);

    // stage transitions
    always_comb begin
        o_flags          = i_flags;
        o_flags.nonempty = 1'b1;
        o_acc            = i_acc;
        do_first         = 1'b0;
        do_add           = 1'b0;
        case (i_flags.stage)
            ST_BLANK: begin
                if (is_blank) begin
                    o_flags.stage = ST_BLANK;
                end else if (i_char == 8'h2B || i_char == 8'h2D) begin
                    o_flags.negative = (i_char == 8'h2D);
                    o_flags.stage    = ST_SIGN;
                end else begin
                    do_first = 1'b1;
                end
            end
            ST_SIGN: begin
                do_first = 1'b1;
            end
            ST_ZERO: begin
                if (i_char == 8'h78 || i_char == 8'h58) begin
                    o_flags.stage = ST_PREFIX;
                end else if (is_hex) begin
                    do_add = 1'b1;
                end else begin
                    o_flags.stage = ST_REST;
                end
            end
            ST_PREFIX, ST_DIGITS: begin
                if (is_hex) begin
                    do_add = 1'b1;
                end else begin
                    o_flags.stage = ST_REST;
                end
            end
            default: begin
                o_flags.stage = i_flags.stage;
            end
        endcase

        // first character of the number proper
        if (do_first) begin
            if (i_char == 8'h30) begin
                o_flags.seen_digit = 1'b1;
                o_flags.stage      = ST_ZERO;
            end else if (is_hex) begin
                do_add = 1'b1;
            end else begin
                o_flags.stage = ST_REST;
            end
        end

        // shift in one digit unless the top nibble is occupied
        if (do_add) begin
            o_flags.seen_digit = 1'b1;
            if (i_acc[LEN_BITS-1 -: 4] != 4'd0) begin
                o_flags.stage = ST_OVER;
            end else begin
                o_acc         = {i_acc[LEN_BITS-5:0], hex_val};
                o_flags.stage = ST_DIGITS;
            end
        end
    end

endmodule

### rtl/http_chunked_body_decoder.sv
// http_chunked_body_decoder: top level, strips chunked transfer framing
// depends on hcbd_pkg and hcbd_size_line
//
// Takes one byte of a chunked body per request on the slave side and gives
// at most one result per byte on the master side. Each chunk-size line is
// parsed like a base-16 strtol (leading blanks, optional sign, optional 0x,
// hex digits, rest ignored; CR dropped, empty lines skipped); the following
// N bytes pass out as payload with tuser 0, then the line after them is
// discarded. A zero length gives one result with tuser 1 (done); a line
// without digits, a nonzero negative value or a length that does not fit in
// LEN_BITS gives tuser 2 (error). After done or error a new body begins.
// Every byte is handled in the cycle it is accepted and the result lands in
// a one-entry output register, so one byte per clock is sustained while
// i_m_tready is high; a byte is taken whenever that register is empty or
// is being drained in the same cycle; its result is valid the cycle after.
module http_chunked_body_decoder import hcbd_pkg::*; #(
    parameter int LEN_BITS = LEN_BITS_DEF
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    // input stream
    input  logic       i_s_tvalid,
    output logic       o_s_tready,
    input  logic [7:0] i_s_tdata,   // [7:0] byte_in
    // result stream
    output logic       o_m_tvalid,
    input  logic       i_m_tready,
    output logic [7:0] o_m_tdata,   // [7:0] data_byte
    output logic [1:0] o_m_tuser    // [1:0] kind
);

    logic [1:0]          r_phase,  n_phase;
    t_line_flags         r_flags,  n_flags;
    logic [LEN_BITS-1:0] r_acc,    n_acc;
    logic [LEN_BITS-1:0] r_left,   n_left;
    logic                r_out_valid;
    logic [1:0]          r_kind;
    logic [7:0]          r_data;

    t_line_flags         char_flags;
    logic [LEN_BITS-1:0] char_acc;
    logic [LEN_BITS-1:0] left_dec;
    logic                accept;
    logic                emit;
    logic [1:0]          emit_kind;
    logic [7:0]          emit_data;

    localparam t_line_flags FLAGS_CLEAR = '{stage: ST_BLANK, nonempty: 1'b0,
                                            negative: 1'b0, seen_digit: 1'b0};

    assign o_s_tready = !r_out_valid || i_m_tready;
    assign accept     = i_s_tvalid && o_s_tready;
    assign left_dec   = r_left - LEN_BITS'(1);

    // size-line character parser
    hcbd_size_line #(
        .LEN_BITS (LEN_BITS)
    ) u_size_line (
        .i_char  (i_s_tdata),
        .i_flags (r_flags),
        .i_acc   (r_acc),
        .o_flags (char_flags),
        .o_acc   (char_acc)
    );

    // per-byte decode
    always_comb begin
        n_phase   = r_phase;
        n_flags   = r_flags;
        n_acc     = r_acc;
        n_left    = r_left;
        emit      = 1'b0;
        emit_kind = KIND_DATA;
        emit_data = 8'd0;
        case (r_phase)
            PH_DATA: begin
                n_left    = left_dec;
                if (left_dec == '0) begin
                    n_phase = PH_TRAIL;
                end
                emit      = 1'b1;
                emit_data = i_s_tdata;
            end
            PH_SIZE: begin
                if (i_s_tdata == CH_CR) begin
                    n_phase = PH_SIZE;
                end else if (i_s_tdata != CH_LF) begin
                    n_flags = char_flags;
                    n_acc   = char_acc;
                end else if (r_flags.nonempty) begin
                    n_flags = FLAGS_CLEAR;
                    n_acc   = '0;
                    if (!r_flags.seen_digit || r_flags.stage == ST_OVER ||
                        (r_flags.negative && r_acc != '0)) begin
                        n_left    = '0;
                        emit      = 1'b1;
                        emit_kind = KIND_ERROR;
                    end else if (r_acc == '0) begin
                        n_left    = '0;
                        emit      = 1'b1;
                        emit_kind = KIND_DONE;
                    end else begin
                        n_left  = r_acc;
                        n_phase = PH_DATA;
                    end
                end
            end
            default: begin
                // trailer line after the payload
                if (i_s_tdata == CH_LF) begin
                    n_phase = PH_SIZE;
                    n_flags = FLAGS_CLEAR;
                    n_acc   = '0;
                end
            end
        endcase
    end

    // decoder state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_SIZE;
            r_flags <= FLAGS_CLEAR;
            r_acc   <= '0;
            r_left  <= '0;
        end else if (accept) begin
            r_phase <= n_phase;
            r_flags <= n_flags;
            r_acc   <= n_acc;
            r_left  <= n_left;
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (accept && emit) begin
            r_out_valid <= 1'b1;
        end else if (i_m_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept && emit) begin
            r_kind <= emit_kind;
            r_data <= emit_data;
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = r_data;
    assign o_m_tuser  = r_kind;

endmodule

### sim/tb_http_chunked_body_decoder.sv
// tb_http_chunked_body_decoder: self-checking bench for the chunked body decoder
// depends on hcbd_pkg and http_chunked_body_decoder; drives bytes, checks results
// against a byte-level model of the size-line parser, payload and trailer phases
`timescale 1ns / 1ps

module tb_http_chunked_body_decoder;
    import hcbd_pkg::*;

    localparam int          LEN_BITS     = LEN_BITS_DEF;
    localparam logic [63:0] LEN_MASK     = (64'd1 << LEN_BITS) - 64'd1;
    localparam int          RANDOM_ITEMS = 1300;
    localparam int          CYCLE_LIMIT  = 200000;
    localparam int          IDLE_PCT     = 13;
    // receiver hold-off window and quiet (no idling) windows
    localparam int          HOLD_START   = 400;
    localparam int          HOLD_CYCLES  = 200;
    localparam int          RX_QUIET_LO  = 900;
    localparam int          RX_QUIET_HI  = 1200;
    localparam int          TX_QUIET_LO  = 800;
    localparam int          TX_QUIET_HI  = 1000;

    // blank characters besides space
    localparam logic [7:0] CH_TAB = 8'h09;
    localparam logic [7:0] CH_VT  = 8'h0B;
    localparam logic [7:0] CH_FF  = 8'h0C;

    // tracks decoder state per accepted byte and holds the results it owes
    class body_decode_scoreboard;
        typedef struct packed {
            logic [1:0] kind;
            logic [7:0] data;
        } t_body_result;

        t_body_result owed_results[$];
        int           errors;

        logic [1:0]  phase;
        logic [2:0]  stage;
        bit          nonempty;
        bit          negative;
        bit          seen_digit;
        logic [63:0] length_acc;
        logic [63:0] bytes_left;

        function new();
            errors = 0;
            restart_body();
        endfunction

        function void clear_line();
            stage      = ST_BLANK;
            nonempty   = 1'b0;
            negative   = 1'b0;
            seen_digit = 1'b0;
            length_acc = '0;
        endfunction

        function void restart_body();
            phase      = PH_SIZE;
            bytes_left = '0;
            clear_line();
        endfunction

        function int hex_value(logic [7:0] c);
            if (c >= "0" && c <= "9") return int'(c - "0");
            if (c >= "a" && c <= "f") return int'(c - "a") + 10;
            if (c >= "A" && c <= "F") return int'(c - "A") + 10;
            return -1;
        endfunction

        // shift in one hex digit unless the top nibble is already in use
        function void take_digit(int d);
            seen_digit = 1'b1;
            if ((length_acc >> (LEN_BITS - 4)) != 64'd0) begin
                stage = ST_OVER;
            end else begin
                length_acc = ((length_acc << 4) | 64'(d)) & LEN_MASK;
                stage      = ST_DIGITS;
            end
        endfunction

        // first character of the number proper, after blanks or a sign
        function void start_number(logic [7:0] c, int d);
            if (c == "0") begin
                seen_digit = 1'b1;
                stage      = ST_ZERO;
            end else if (d >= 0) begin
                take_digit(d);
            end else begin
                stage = ST_REST;
            end
        endfunction

        function void size_char(logic [7:0] c);
            int d;
            d        = hex_value(c);
            nonempty = 1'b1;
            case (stage)
                ST_BLANK: begin
                    if (c == " " || c == CH_TAB || c == CH_VT || c == CH_FF) begin
                    end else if (c == "+" || c == "-") begin
                        negative = (c == "-");
                        stage    = ST_SIGN;
                    end else begin
                        start_number(c, d);
                    end
                end
                ST_SIGN: start_number(c, d);
                ST_ZERO: begin
                    if (c == "x" || c == "X") stage = ST_PREFIX;
                    else if (d >= 0) take_digit(d);
                    else stage = ST_REST;
                end
                ST_PREFIX, ST_DIGITS: begin
                    if (d >= 0) take_digit(d);
                    else stage = ST_REST;
                end
                default: ;
            endcase
        endfunction

        // one accepted request: advance the state, queue any result it causes
        function void note_request(logic [7:0] c);
            t_body_result r;
            if (phase == PH_DATA) begin
                bytes_left = (bytes_left - 64'd1) & LEN_MASK;
                if (bytes_left == 64'd0) phase = PH_TRAIL;
                r.kind = KIND_DATA;
                r.data = c;
                owed_results.push_back(r);
                return;
            end
            if (phase != PH_SIZE) begin
                if (c == CH_LF) begin
                    phase = PH_SIZE;
                    clear_line();
                end
                return;
            end
            if (c == CH_CR) return;
            if (c != CH_LF) begin
                size_char(c);
                return;
            end
            // end of a size line
            if (!nonempty) return;
            r.data = 8'h00;
            if (!seen_digit || stage == ST_OVER || (negative && length_acc != 64'd0)) begin
                restart_body();
                r.kind = KIND_ERROR;
                owed_results.push_back(r);
                return;
            end
            if (length_acc == 64'd0) begin
                restart_body();
                r.kind = KIND_DONE;
                owed_results.push_back(r);
                return;
            end
            bytes_left = length_acc;
            phase      = PH_DATA;
            clear_line();
        endfunction

        function void check_output(logic [1:0] kind, logic [7:0] data);
            t_body_result want;
            if (owed_results.size() == 0) begin
                $display("%0t: unexpected result kind %0d data %02h", $time, kind, data);
                errors++;
                return;
            end
            want = owed_results.pop_front();
            if (kind !== want.kind) begin
                $display("%0t: kind mismatch, expected %0d actual %0d",
                         $time, want.kind, kind);
                errors++;
            end
            if (data !== want.data) begin
                $display("%0t: data mismatch, expected %02h actual %02h",
                         $time, want.data, data);
                errors++;
            end
        endfunction
    endclass

    logic       i_clk      = 1'b0;
    logic       i_rst_n    = 1'b0;
    logic       i_s_tvalid = 1'b0;
    logic [7:0] i_s_tdata  = 8'h00;
    logic       i_m_tready = 1'b0;
    logic       o_s_tready;
    logic       o_m_tvalid;
    logic [7:0] o_m_tdata;
    logic [1:0] o_m_tuser;

    body_decode_scoreboard sb;
    int items_sent = 0;
    int rx_cycle   = 0;
    int run_cycle  = 0;

    http_chunked_body_decoder #(.LEN_BITS(LEN_BITS)) dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata),
        .o_m_tuser  (o_m_tuser)
    );

    always #4 i_clk = ~i_clk;

    // watchdog on the whole run
    always @(posedge i_clk) begin
        run_cycle++;
        if (run_cycle > CYCLE_LIMIT) begin
            $display("*** FAILED ***");
            $finish;
        end
    end

    // result side: check on each handshake, then pick the next tready
    always @(posedge i_clk) begin
        if (i_rst_n && o_m_tvalid && i_m_tready) sb.check_output(o_m_tuser, o_m_tdata);
        if (i_rst_n) rx_cycle++;
        if (rx_cycle >= HOLD_START && rx_cycle < HOLD_START + HOLD_CYCLES) begin
            i_m_tready <= 1'b0;
        end else if (rx_cycle >= RX_QUIET_LO && rx_cycle < RX_QUIET_HI) begin
            i_m_tready <= 1'b1;
        end else begin
            i_m_tready <= ($urandom_range(99) >= IDLE_PCT);
        end
    end

    // offer one byte, idling first at random, and wait for the handshake
    task automatic send_byte(input logic [7:0] b);
        bit quiet;
        quiet = (items_sent >= TX_QUIET_LO && items_sent < TX_QUIET_HI);
        while (!quiet && $urandom_range(99) < IDLE_PCT) begin
            i_s_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        i_s_tvalid <= 1'b1;
        i_s_tdata  <= b;
        @(posedge i_clk);
        while (!o_s_tready) @(posedge i_clk);
        sb.note_request(b);
        items_sent++;
    endtask

    task automatic send_text(input string s);
        for (int i = 0; i < s.len(); i++) send_byte(s[i]);
    endtask

    // size line in one of many legal spellings, optional CR before LF
    task automatic send_size_line(input logic [63:0] len);
        string line;
        string digits;
        int    pick;
        line   = "";
        digits = $sformatf("%0h", len);
        repeat ($urandom_range(0, 2)) begin
            pick = $urandom_range(3);
            line = $sformatf("%s%c", line, (pick == 0) ? " " :
                             (pick == 1) ? CH_TAB : (pick == 2) ? CH_VT : CH_FF);
        end
        pick = $urandom_range(11);
        if (pick == 0) line = {line, "+"};
        else if (pick == 1 && len == 64'd0) line = {line, "-"};
        pick = $urandom_range(7);
        if (pick == 0) line = {line, "0x"};
        else if (pick == 1) line = {line, "0X"};
        if ($urandom_range(4) == 0) line = {line, "00"};
        // mixed case hex digits
        for (int i = 0; i < digits.len(); i++) begin
            if (digits[i] >= "a" && digits[i] <= "f" && $urandom_range(1) == 1)
                digits[i] = digits[i] - 8'd32;
        end
        line = {line, digits};
        pick = $urandom_range(9);
        if (pick == 0) line = {line, ";name=val"};
        else if (pick == 1) line = {line, " ;x"};
        else if (pick == 2) line = {line, "zq"};
        send_text(line);
        if ($urandom_range(3) != 0) send_byte(CH_CR);
        send_byte(CH_LF);
    endtask

    // finish whatever line or payload is open so a fresh body can start
    task automatic resync();
        forever begin
            if (sb.phase == PH_DATA) send_byte(8'($urandom_range(255)));
            else if (sb.phase == PH_TRAIL || sb.nonempty) send_byte(CH_LF);
            else break;
        end
    endtask

    // well-formed chunks with random content, then a clean or broken last line
    task automatic send_body();
        int    len;
        int    pick;
        string enders[9];
        enders = '{"-a", "g", " ", "123456789", "x1", "+-2", "0x-", "-0", "0x"};
        resync();
        repeat ($urandom_range(1, 4)) begin
            if ($urandom_range(9) == 0) begin
                send_byte(CH_CR);
                send_byte(CH_LF);
            end
            len = ($urandom_range(19) == 0) ? $urandom_range(64, 300) : $urandom_range(1, 16);
            send_size_line(64'(len));
            repeat (len) begin
                pick = $urandom_range(7);
                send_byte((pick == 0) ? CH_CR : (pick == 1) ? CH_LF :
                          8'($urandom_range(255)));
            end
            // trailer line: usually bare CRLF, sometimes junk first
            if ($urandom_range(3) == 0) begin
                repeat ($urandom_range(1, 4)) send_byte(8'($urandom_range(11, 255)));
            end
            send_byte(CH_CR);
            send_byte(CH_LF);
        end
        if ($urandom_range(9) < 7) begin
            send_size_line(64'd0);
        end else begin
            send_text(enders[$urandom_range(8)]);
            send_byte(CH_LF);
        end
    endtask

    initial begin
        sb = new();
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: empty line with CR, signed zero, lone prefix, minus error
        send_byte(CH_CR);
        send_byte(CH_LF);
        send_text("\t-0\n");
        send_text("0x\n");
        send_text("-1\n");
        // blanks only
        send_byte(CH_VT);
        send_byte(CH_FF);
        send_text(" \n");
        // three payload bytes (00, FF and an LF) and a discarded trailer
        send_text("+3;x");
        send_byte(CH_CR);
        send_byte(CH_LF);
        send_byte(8'h00);
        send_byte(8'hFF);
        send_byte(CH_LF);
        send_text("t\n");
        send_text("0\n");
        // length too wide for the counter
        send_text("1FFFFFFFF\n");

        // random: mostly bodies, some short noisy lines
        while (items_sent < RANDOM_ITEMS) begin
            if ($urandom_range(99) < 80) begin
                send_body();
            end else begin
                repeat ($urandom_range(1, 2)) send_byte(8'($urandom_range(255)));
                send_byte(CH_LF);
            end
        end
        i_s_tvalid <= 1'b0;

        // drain and let the output register settle
        while (sb.owed_results.size() != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);
        if (sb.errors == 0 && sb.owed_results.size() == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule
